### rtl/core/hbs_pkg.sv
package hbs_pkg;

    localparam int MAX_TARGETS   = 8;
    localparam int WEIGHT_CAP    = 1000;
    localparam int LATENCY_BITS  = 24;

    localparam int TGT_W         = $clog2(MAX_TARGETS);
    localparam int CNT_W         = $clog2(MAX_TARGETS + 1);
    localparam int COUNT_FIELD_W = 4;
    localparam int WEIGHT_W      = 10;
    localparam int LAT_FIELD_W   = 24;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;

    localparam int LFSR_W        = 32;
    localparam logic [LFSR_W-1:0] LFSR_MASK = 32'h8020_0003;
    localparam int DIV_DIGIT     = 4;
    localparam int DIV_STEPS     = LFSR_W / DIV_DIGIT;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_PROBE = 2'd1;
    localparam logic [1:0] MODE_PICK  = 2'd2;

    localparam logic [1:0] STRAT_RR  = 2'd0;
    localparam logic [1:0] STRAT_LAT = 2'd1;
    localparam logic [1:0] STRAT_RND = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_STRATEGY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEALTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RR_NORM,
        ST_RR_SCAN,
        ST_LAT_SCAN,
        ST_RND_DIV,
        ST_RND_SEL,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic table_write;
        logic pick_empty;
        logic rr_init;
        logic rr_norm;
        logic rr_step;
        logic lat_init;
        logic lat_step;
        logic rnd_init;
        logic div_step;
        logic sel_step;
    } t_dp_cmd;

    typedef struct packed {
        logic n_zero;
        logic use_lat;
        logic use_rnd;
        logic cur_elig;
        logic idx_last;
        logic div_last;
        logic sel_hit;
    } t_dp_status;

endpackage

### rtl/core/hbs_ctrl.sv
module hbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_mode,
    input  hbs_pkg::t_dp_status i_status,
    output hbs_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_result_valid
);
    import hbs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_mode == MODE_PICK) begin
                    if (i_status.n_zero) begin
                        n_state = ST_RESULT;
                    end else if (i_status.use_lat) begin
                        n_state = ST_LAT_SCAN;
                    end else if (i_status.use_rnd) begin
                        n_state = ST_RND_DIV;
                    end else begin
                        n_state = ST_RR_NORM;
                    end
                end
            end
            ST_RR_NORM:  n_state = ST_RR_SCAN;
            ST_RR_SCAN: begin
                if (i_status.cur_elig) begin
                    n_state = ST_RESULT;
                end
            end
            ST_LAT_SCAN: begin
                if (i_status.idx_last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RND_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_RND_SEL;
                end
            end
            ST_RND_SEL: begin
                if (i_status.sel_hit) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT:   n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_busy         = 1'b1;
        o_result_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (accept) begin
                    if (i_mode == MODE_LOAD || i_mode == MODE_PROBE) begin
                        o_cmd.table_write = 1'b1;
                    end else if (i_mode == MODE_PICK) begin
                        if (i_status.n_zero) begin
                            o_cmd.pick_empty = 1'b1;
                        end else if (i_status.use_lat) begin
                            o_cmd.lat_init = 1'b1;
                        end else if (i_status.use_rnd) begin
                            o_cmd.rnd_init = 1'b1;
                        end else begin
                            o_cmd.rr_init = 1'b1;
                        end
                    end
                end
            end
            ST_RR_NORM:  o_cmd.rr_norm  = 1'b1;
            ST_RR_SCAN:  o_cmd.rr_step  = 1'b1;
            ST_LAT_SCAN: o_cmd.lat_step = 1'b1;
            ST_RND_DIV:  o_cmd.div_step = 1'b1;
            ST_RND_SEL:  o_cmd.sel_step = 1'b1;
            ST_RESULT:   o_result_valid = 1'b1;
            default:     o_busy = 1'b1;
        endcase
    end

    // a result strobe lasts exactly one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    // busy drops only right after a result has been shown
    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> $past(o_result_valid))
        else $error("pick finished without a result");

    // no new transaction can slip in during the result cycle
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_busy)
        else $error("result shown while accepting commands");

endmodule

### rtl/core/hbs_datapath.sv
module hbs_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hbs_pkg::t_dp_cmd                     i_cmd,
    output hbs_pkg::t_dp_status                  o_status,
    input  logic [1:0]                           i_mode,
    input  logic [hbs_pkg::TGT_W-1:0]            i_target,
    input  logic [hbs_pkg::WEIGHT_W-1:0]         i_weight,
    input  logic                                 i_probe_ok,
    input  logic [hbs_pkg::LAT_FIELD_W-1:0]      i_latency_us,
    input  logic                                 i_cfg_write,
    input  logic [hbs_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_found,
    output logic [hbs_pkg::TGT_W-1:0]            o_chosen_target
);
    import hbs_pkg::*;

    // configuration
    logic [1:0]               r_strategy;
    logic                     r_health_en;
    logic [COUNT_FIELD_W-1:0] r_target_count;
    logic [LFSR_W-1:0]        r_lfsr;

    // per-target tables
    logic [WEIGHT_W-1:0]      r_weight [MAX_TARGETS];
    logic [MAX_TARGETS-1:0]   r_up;
    logic [LATENCY_BITS-1:0]  r_lat [MAX_TARGETS];

    // round robin cursor
    logic [TGT_W-1:0]         r_wheel_tgt;
    logic [WEIGHT_W-1:0]      r_wheel_rep;

    // scan state
    logic [TGT_W-1:0]         r_idx;
    logic [WEIGHT_W-1:0]      r_rep;
    logic                     r_have;
    logic [LATENCY_BITS-1:0]  r_best_lat;
    logic [CNT_W-1:0]         r_seen;
    logic [CNT_W-1:0]         r_rem;
    logic [DIV_CNT_W-1:0]     r_div_cnt;
    logic [LFSR_W-1:0]        r_div_src;
    logic                     r_found;
    logic [TGT_W-1:0]         r_chosen;

    logic [CNT_W-1:0]         active_cnt;
    logic [MAX_TARGETS-1:0]   active;
    logic [MAX_TARGETS-1:0]   healthy;
    logic [MAX_TARGETS-1:0]   elig;
    logic                     some_up;
    logic [CNT_W-1:0]         elig_cnt;
    logic [CNT_W-1:0]         idx_inc;
    logic [TGT_W-1:0]         idx_next;
    logic [WEIGHT_W-1:0]      cur_weight;
    logic [LATENCY_BITS-1:0]  cur_lat;
    logic                     cur_elig;
    logic [WEIGHT_W:0]        rep_inc;
    logic [WEIGHT_W-1:0]      w_load;
    logic [LFSR_W-1:0]        lfsr_next;
    logic [CNT_W-1:0]         rem_next;
    logic [CNT_W-1:0]         wheel_tgt_ext;

    assign active_cnt = (r_target_count > COUNT_FIELD_W'(MAX_TARGETS)) ?
                        CNT_W'(MAX_TARGETS) : CNT_W'(r_target_count);

    always_comb begin
        for (int i = 0; i < MAX_TARGETS; i++) begin
            active[i]  = CNT_W'(i) < active_cnt;
            healthy[i] = !r_health_en || r_up[i];
        end
        some_up = |(active & healthy);
        // fail open: with nobody healthy every active target counts
        elig = active & (some_up ? healthy : {MAX_TARGETS{1'b1}});
        elig_cnt = '0;
        for (int i = 0; i < MAX_TARGETS; i++) begin
            elig_cnt = elig_cnt + CNT_W'(elig[i]);
        end
    end

    assign idx_inc       = CNT_W'(r_idx) + CNT_W'(1);
    assign idx_next      = (idx_inc >= active_cnt) ? '0 : idx_inc[TGT_W-1:0];
    assign cur_weight    = r_weight[r_idx];
    assign cur_lat       = r_lat[r_idx];
    assign cur_elig      = elig[r_idx];
    assign rep_inc       = {1'b0, r_rep} + (WEIGHT_W+1)'(1);
    assign wheel_tgt_ext = CNT_W'(r_wheel_tgt);

    always_comb begin
        w_load = i_weight;
        if (i_weight == '0) begin
            w_load = WEIGHT_W'(1);
        end else if (i_weight > WEIGHT_W'(WEIGHT_CAP)) begin
            w_load = WEIGHT_W'(WEIGHT_CAP);
        end
    end

    // Galois step, shifting right
    assign lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_MASK) : (r_lfsr >> 1);

    // restoring remainder, one digit of the draw per cycle
    always_comb begin
        logic [DIV_DIGIT-1:0] digit;
        digit    = r_div_src[LFSR_W-1 -: DIV_DIGIT];
        rem_next = r_rem;
        for (int j = DIV_DIGIT - 1; j >= 0; j--) begin
            rem_next = {rem_next[CNT_W-2:0], digit[j]};
            if (rem_next >= elig_cnt) begin
                rem_next = rem_next - elig_cnt;
            end
        end
    end

    always_comb begin
        o_status          = '0;
        o_status.n_zero   = active_cnt == '0;
        o_status.use_lat  = (r_strategy == STRAT_LAT) && r_health_en;
        o_status.use_rnd  = r_strategy == STRAT_RND;
        o_status.cur_elig = cur_elig;
        o_status.idx_last = idx_inc == active_cnt;
        o_status.div_last = r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
        o_status.sel_hit  = cur_elig && (r_seen == r_rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy     <= STRAT_RR;
            r_health_en    <= 1'b0;
            r_target_count <= '0;
            r_lfsr         <= LFSR_W'(1);
            r_up           <= '0;
            for (int i = 0; i < MAX_TARGETS; i++) begin
                r_weight[i] <= WEIGHT_W'(1);
                r_lat[i]    <= '0;
            end
            r_wheel_tgt <= '0;
            r_wheel_rep <= '0;
            r_idx       <= '0;
            r_rep       <= '0;
            r_have      <= 1'b0;
            r_best_lat  <= '0;
            r_seen      <= '0;
            r_rem       <= '0;
            r_div_cnt   <= '0;
            r_div_src   <= '0;
            r_found     <= 1'b0;
            r_chosen    <= '0;
        end else begin
            if (i_cfg_write) begin
                case (i_cfg_index)
                    CFG_STRATEGY: r_strategy     <= i_cfg_data[1:0];
                    CFG_HEALTH:   r_health_en    <= i_cfg_data[0];
                    CFG_COUNT:    r_target_count <= i_cfg_data[COUNT_FIELD_W-1:0];
                    CFG_SEED:     r_lfsr <= (i_cfg_data == '0) ? LFSR_W'(1) : i_cfg_data;
                    default:      r_strategy     <= r_strategy;
                endcase
            end

            if (i_cmd.table_write) begin
                if (i_mode == MODE_LOAD) begin
                    r_weight[i_target] <= w_load;
                    r_wheel_tgt        <= '0;
                    r_wheel_rep        <= '0;
                end else begin
                    r_up[i_target] <= i_probe_ok;
                    if (i_probe_ok) begin
                        r_lat[i_target] <= i_latency_us[LATENCY_BITS-1:0];
                    end
                end
            end

            if (i_cmd.pick_empty) begin
                r_found  <= 1'b0;
                r_chosen <= '0;
            end

            if (i_cmd.rr_init) begin
                r_found <= 1'b1;
                if (wheel_tgt_ext >= active_cnt) begin
                    r_idx <= '0;
                    r_rep <= '0;
                end else begin
                    r_idx <= r_wheel_tgt;
                    r_rep <= r_wheel_rep;
                end
            end

            if (i_cmd.rr_norm && r_rep >= cur_weight) begin
                r_idx <= idx_next;
                r_rep <= '0;
            end

            if (i_cmd.rr_step) begin
                if (cur_elig) begin
                    r_chosen <= r_idx;
                    if (rep_inc >= {1'b0, cur_weight}) begin
                        r_wheel_tgt <= idx_next;
                        r_wheel_rep <= '0;
                    end else begin
                        r_wheel_tgt <= r_idx;
                        r_wheel_rep <= rep_inc[WEIGHT_W-1:0];
                    end
                end else begin
                    // skip the rest of this target's slots
                    r_idx <= idx_next;
                    r_rep <= '0;
                end
            end

            if (i_cmd.lat_init) begin
                r_found <= 1'b1;
                r_idx   <= '0;
                r_have  <= 1'b0;
            end

            if (i_cmd.lat_step) begin
                if (cur_elig && (!r_have || cur_lat < r_best_lat)) begin
                    r_chosen   <= r_idx;
                    r_best_lat <= cur_lat;
                    r_have     <= 1'b1;
                end
                r_idx <= idx_next;
            end

            if (i_cmd.rnd_init) begin
                r_found   <= 1'b1;
                r_lfsr    <= lfsr_next;
                r_div_src <= lfsr_next;
                r_div_cnt <= '0;
                r_rem     <= '0;
                r_idx     <= '0;
                r_seen    <= '0;
            end

            if (i_cmd.div_step) begin
                r_rem     <= rem_next;
                r_div_src <= r_div_src << DIV_DIGIT;
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end

            if (i_cmd.sel_step) begin
                if (cur_elig) begin
                    if (r_seen == r_rem) begin
                        r_chosen <= r_idx;
                    end else begin
                        r_seen <= r_seen + CNT_W'(1);
                    end
                end
                r_idx <= idx_next;
            end
        end
    end

    assign o_found         = r_found;
    assign o_chosen_target = r_chosen;

    // the stored cursor always points inside its target's run of slots
    a_cursor_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wheel_rep < r_weight[r_wheel_tgt])
        else $error("round robin cursor past its target's weight");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("random generator reached the all-zero state");

    // the draw position is a valid eligible slot once selection starts
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sel_step |-> (r_rem < elig_cnt))
        else $error("draw position beyond eligible count");

endmodule

### rtl/core/health_aware_backend_selector_core.sv
// Picks one of up to eight backend targets by weighted round robin, lowest
// latency (when health checking is on) or a seeded pseudo-random draw, and,
// with health checking on, skips targets whose last probe failed unless none
// is up. Weight loads and probe reports are taken in the same cycle as start
// and leave busy low. A pick raises busy and ends with one result cycle on
// o_result_valid, which the receiver must take as it comes. Round robin runs
// a normalize step, then a scan over the targets until it meets an eligible
// one. Lowest latency scans every active target once. Random first reduces
// the draw in the remainder unit, four bits of the draw per cycle, then scans
// to the chosen position. A pick with no targets configured goes straight to
// the result with found low. Configuration writes are taken while busy and
// start are both low.
module health_aware_backend_selector_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_mode,
    input  logic [hbs_pkg::TGT_W-1:0]          i_target,
    input  logic [hbs_pkg::WEIGHT_W-1:0]       i_weight,
    input  logic                               i_probe_ok,
    input  logic [hbs_pkg::LAT_FIELD_W-1:0]    i_latency_us,
    output logic                               o_result_valid,
    output logic                               o_found,
    output logic [hbs_pkg::TGT_W-1:0]          o_chosen_target,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hbs_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import hbs_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       cfg_write;

    // hold register writes off while busy or while a command transaction is offered
    assign o_cfg_ready = !busy && !start;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    hbs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_mode         (i_mode),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    hbs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_mode          (i_mode),
        .i_target        (i_target),
        .i_weight        (i_weight),
        .i_probe_ok      (i_probe_ok),
        .i_latency_us    (i_latency_us),
        .i_cfg_write     (cfg_write),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_found         (o_found),
        .o_chosen_target (o_chosen_target)
    );

endmodule
